// File: sv/relay_channel_scheduler_top_macros.svh
// Assertion macros used by the relay channel scheduler controller, rcs_ctrl.
// Depends on nothing; the asserting module must have ports named clock and reset.
`ifndef RELAY_CHANNEL_SCHEDULER_TOP_MACROS_SVH
`define RELAY_CHANNEL_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RCS_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rcs_pkg.sv
// Shared types, codes and constants of the relay channel scheduler.
// Depends on nothing; every RTL module refers to it by scoped names.
package rcs_pkg;

   localparam int TIMER_SLOTS = 8;
   localparam int SLOT_AW     = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int SLOT_IN_W   = 3;
   localparam int SLOT_CMP_W  = 6;

   // Seconds of the day from hour, minute and second fields (max 115443).
   localparam int TOD_W = 17;
   localparam int DUR_W = 17;
   // duty * range, range * 100, and those times ten.
   localparam int DR_W  = 23;
   localparam int MS_W  = 27;
   // auto_off_s * 1000.
   localparam int AO_W  = 26;

   localparam logic [TOD_W-1:0] SEC_PER_HOUR = TOD_W'(3600);
   localparam logic [TOD_W-1:0] SEC_PER_MIN  = TOD_W'(60);
   localparam logic [AO_W-1:0]  MS_PER_SEC   = AO_W'(1000);
   localparam logic [DR_W-1:0]  PERCENT_FULL = DR_W'(100);
   localparam logic [MS_W-1:0]  MS_PER_PCT_S = MS_W'(10);
   localparam logic [6:0]       DUTY_MAX     = 7'd100;
   localparam logic [15:0]      RANGE_MIN    = 16'd2;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_SLOT = 2'd2;

   localparam logic [1:0] MODE_MANUAL = 2'd0;
   localparam logic [1:0] MODE_DUTY   = 2'd1;
   localparam logic [1:0] MODE_DAILY  = 2'd2;
   localparam logic [1:0] MODE_EPOCH  = 2'd3;

   localparam logic [2:0] CSR_MODE         = 3'd0;
   localparam logic [2:0] CSR_DUTY_PERCENT = 3'd1;
   localparam logic [2:0] CSR_DUTY_RANGE   = 3'd2;
   localparam logic [2:0] CSR_AUTO_OFF     = 3'd3;
   localparam logic [2:0] CSR_START_EPOCH  = 3'd4;
   localparam logic [2:0] CSR_RUN_DURATION = 3'd5;
   localparam logic [2:0] CSR_ACTIVE_LEVEL = 3'd6;

   typedef struct packed {
      logic [4:0]       hour;
      logic [5:0]       minute;
      logic [5:0]       second;
      logic [DUR_W-1:0] duration;
   } slot_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [6:0]  duty_percent;
      logic [15:0] duty_range_s;
      logic [15:0] auto_off_s;
      logic [31:0] start_epoch;
      logic [31:0] run_duration_s;
      logic        active_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [31:0]          now_ms;
      logic [31:0]          epoch_s;
      logic [4:0]           hour;
      logic [5:0]           minute;
      logic [5:0]           second;
      logic                 panic;
      logic                 set_on;
      logic [SLOT_IN_W-1:0] slot;
      logic [DUR_W-1:0]     slot_duration;
   } item_type;

   typedef struct packed {
      logic               wr_en;
      logic [SLOT_AW-1:0] wr_addr;
      slot_type           wr_data;
      logic               rd_en;
      logic [SLOT_AW-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   function automatic logic [TOD_W-1:0] tod_sec(input logic [4:0] h, input logic [5:0] m,
                                               input logic [5:0] s);
      tod_sec = TOD_W'(h) * SEC_PER_HOUR + TOD_W'(m) * SEC_PER_MIN + TOD_W'(s);
   endfunction

endpackage

// File: sv/rcs_csr.sv
// Configuration registers of the relay channel scheduler.
// Depends on rcs_pkg for the register indexes and the configuration struct.
module rcs_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output rcs_pkg::cfg_type   cfg
);

   rcs_pkg::cfg_type cfg_ff;
   rcs_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rcs_pkg::CSR_MODE:         cfg_in.mode           = csr_data[1:0];
            rcs_pkg::CSR_DUTY_PERCENT: cfg_in.duty_percent   = csr_data[6:0];
            rcs_pkg::CSR_DUTY_RANGE:   cfg_in.duty_range_s   = csr_data[15:0];
            rcs_pkg::CSR_AUTO_OFF:     cfg_in.auto_off_s     = csr_data[15:0];
            rcs_pkg::CSR_START_EPOCH:  cfg_in.start_epoch    = csr_data;
            rcs_pkg::CSR_RUN_DURATION: cfg_in.run_duration_s = csr_data;
            rcs_pkg::CSR_ACTIVE_LEVEL: cfg_in.active_level   = csr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{active_level: 1'b1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/rcs_slot_mem.sv
// Daily timer table: a one-port-write, one-port-read memory with registered read data.
// Depends on rcs_pkg; per-entry valid bits make unwritten entries read as zero.
module rcs_slot_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  rcs_pkg::mem_req_type mem_req,
   output rcs_pkg::slot_type    rd_data
);

   rcs_pkg::slot_type                  mem_ff [rcs_pkg::TIMER_SLOTS];
   logic [rcs_pkg::TIMER_SLOTS-1:0]    valid_ff;
   logic [rcs_pkg::TIMER_SLOTS-1:0]    valid_in;
   rcs_pkg::slot_type                  rd_data_ff;

   assign rd_data = rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= valid_ff[mem_req.rd_addr] ? mem_ff[mem_req.rd_addr] : '0;
      end
   end

endmodule

// File: sv/rcs_ctrl.sv
// Sequencer and datapath of the relay channel scheduler: relay state, timing, table walk.
// Depends on rcs_pkg and the assertion macros in relay_channel_scheduler_top_macros.svh.
`include "relay_channel_scheduler_top_macros.svh"

module rcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rcs_pkg::item_type    item,
   input  rcs_pkg::cfg_type     cfg,
   output rcs_pkg::mem_req_type mem_req,
   input  rcs_pkg::slot_type    rd_data,
   output logic                 rsp_valid,
   output logic                 rsp_relay_on,
   output logic                 rsp_pin_level,
   output logic                 rsp_switched
);

   rcs_pkg::state_type state_ff, state_in;

   rcs_pkg::item_type  item_ff, item_in;
   logic               relay_ff, relay_in;
   logic [31:0]        last_on_ff, last_on_in;
   logic [31:0]        last_chg_ff, last_chg_in;

   logic [rcs_pkg::SLOT_AW-1:0] cnt_ff, cnt_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic                        any_ff, any_in;

   logic [6:0]                 duty_ff, duty_in;
   logic [rcs_pkg::DR_W-1:0]   dr_ff, dr_in;
   logic [rcs_pkg::DR_W-1:0]   r100_ff, r100_in;
   logic [rcs_pkg::AO_W-1:0]   ao_ms_ff, ao_ms_in;
   logic [rcs_pkg::MS_W-1:0]   on_ms_ff, on_ms_in;
   logic [rcs_pkg::MS_W-1:0]   off_ms_ff, off_ms_in;
   logic [rcs_pkg::TOD_W-1:0]  cur_ff, cur_in;
   logic [31:0]                el_on_ff, el_on_in;
   logic [31:0]                el_chg_ff, el_chg_in;
   logic [31:0]                since_ff, since_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_relay_ff, rsp_relay_in;
   logic rsp_pin_ff, rsp_pin_in;
   logic rsp_sw_ff, rsp_sw_in;

   logic                         accept;
   logic                         go_scan;
   logic [15:0]                  range_clamped;
   logic [rcs_pkg::TOD_W-1:0]    slot_start;
   logic [rcs_pkg::TOD_W:0]      slot_end;
   logic                         hit;
   logic                         drive;
   logic                         drive_on;
   logic                         relay_new;
   logic [rcs_pkg::SLOT_CMP_W-1:0] slot_ext;

   assign accept   = start && (state_ff == rcs_pkg::ST_IDLE);
   assign go_scan  = (item_ff.op == rcs_pkg::OP_TICK) && !item_ff.panic &&
                     (cfg.mode == rcs_pkg::MODE_DAILY);
   assign slot_ext = rcs_pkg::SLOT_CMP_W'(item_ff.slot);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcs_pkg::ST_IDLE:   if (accept) state_in = rcs_pkg::ST_PREP;
         rcs_pkg::ST_PREP:   state_in = rcs_pkg::ST_MUL;
         rcs_pkg::ST_MUL:    state_in = go_scan ? rcs_pkg::ST_SCAN : rcs_pkg::ST_DECIDE;
         rcs_pkg::ST_SCAN: begin
            if (cnt_ff == rcs_pkg::SLOT_AW'(rcs_pkg::TIMER_SLOTS - 1)) begin
               state_in = rcs_pkg::ST_DRAIN;
            end
         end
         rcs_pkg::ST_DRAIN:  state_in = rcs_pkg::ST_DECIDE;
         rcs_pkg::ST_DECIDE: state_in = rcs_pkg::ST_IDLE;
         default:            state_in = rcs_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and memory accesses.
   always_comb begin
      busy            = (state_ff != rcs_pkg::ST_IDLE);
      mem_req.rd_en   = (state_ff == rcs_pkg::ST_SCAN);
      mem_req.rd_addr = cnt_ff;
      mem_req.wr_en   = (state_ff == rcs_pkg::ST_DECIDE) && (item_ff.op == rcs_pkg::OP_SLOT) &&
                        (slot_ext < rcs_pkg::SLOT_CMP_W'(rcs_pkg::TIMER_SLOTS));
      mem_req.wr_addr = slot_ext[rcs_pkg::SLOT_AW-1:0];
      mem_req.wr_data.hour     = item_ff.hour;
      mem_req.wr_data.minute   = item_ff.minute;
      mem_req.wr_data.second   = item_ff.second;
      mem_req.wr_data.duration = item_ff.slot_duration;
   end

   // Window check on the entry read in the previous cycle; no wrap at midnight.
   always_comb begin
      slot_start = rcs_pkg::tod_sec(rd_data.hour, rd_data.minute, rd_data.second);
      slot_end   = (rcs_pkg::TOD_W + 1)'(slot_start) + (rcs_pkg::TOD_W + 1)'(rd_data.duration);
      hit        = (slot_start <= cur_ff) && (slot_end >= (rcs_pkg::TOD_W + 1)'(cur_ff));
   end

   // Relay decision for the held item.
   always_comb begin
      drive    = 1'b0;
      drive_on = 1'b0;
      case (item_ff.op)
         rcs_pkg::OP_TICK: begin
            if (item_ff.panic) begin
               drive = 1'b1;
            end else begin
               case (cfg.mode)
                  rcs_pkg::MODE_MANUAL: begin
                     if (cfg.auto_off_s != 16'd0 && relay_ff && el_on_ff >= 32'(ao_ms_ff)) begin
                        drive = 1'b1;
                     end
                  end
                  rcs_pkg::MODE_DUTY: begin
                     if (duty_ff != 7'd0) begin
                        if (relay_ff) begin
                           if (duty_ff != rcs_pkg::DUTY_MAX && el_chg_ff >= 32'(on_ms_ff)) begin
                              drive = 1'b1;
                           end
                        end else if (el_chg_ff >= 32'(off_ms_ff)) begin
                           drive    = 1'b1;
                           drive_on = 1'b1;
                        end
                     end
                  end
                  rcs_pkg::MODE_DAILY: begin
                     if (!relay_ff && any_ff) begin
                        drive    = 1'b1;
                        drive_on = 1'b1;
                     end else if (relay_ff && !any_ff) begin
                        drive = 1'b1;
                     end
                  end
                  rcs_pkg::MODE_EPOCH: begin
                     if (cfg.run_duration_s != 32'd0) begin
                        if (cfg.start_epoch <= item_ff.epoch_s &&
                            cfg.run_duration_s >= since_ff && !relay_ff) begin
                           drive    = 1'b1;
                           drive_on = 1'b1;
                        end else if (relay_ff && cfg.run_duration_s <= since_ff) begin
                           drive = 1'b1;
                        end
                     end
                  end
                  default: drive = 1'b0;
               endcase
            end
         end
         rcs_pkg::OP_SET: begin
            drive    = 1'b1;
            drive_on = item_ff.set_on;
         end
         default: drive = 1'b0;
      endcase
      relay_new = drive ? drive_on : relay_ff;
   end

   // Datapath next values.
   always_comb begin
      item_in     = accept ? item : item_ff;
      relay_in    = relay_ff;
      last_on_in  = last_on_ff;
      last_chg_in = last_chg_ff;
      cnt_in      = cnt_ff;
      rd_pend_in  = (state_ff == rcs_pkg::ST_SCAN);
      any_in      = any_ff;
      duty_in     = duty_ff;
      dr_in       = dr_ff;
      r100_in     = r100_ff;
      ao_ms_in    = ao_ms_ff;
      on_ms_in    = on_ms_ff;
      off_ms_in   = off_ms_ff;
      cur_in      = cur_ff;
      el_on_in    = el_on_ff;
      el_chg_in   = el_chg_ff;
      since_in    = since_ff;
      range_clamped = (cfg.duty_range_s < rcs_pkg::RANGE_MIN) ? rcs_pkg::RANGE_MIN
                                                               : cfg.duty_range_s;

      if (state_ff == rcs_pkg::ST_PREP) begin
         duty_in   = (cfg.duty_percent > rcs_pkg::DUTY_MAX) ? rcs_pkg::DUTY_MAX
                                                             : cfg.duty_percent;
         dr_in     = rcs_pkg::DR_W'(duty_in) * rcs_pkg::DR_W'(range_clamped);
         r100_in   = rcs_pkg::DR_W'(range_clamped) * rcs_pkg::PERCENT_FULL;
         ao_ms_in  = rcs_pkg::AO_W'(cfg.auto_off_s) * rcs_pkg::MS_PER_SEC;
         cur_in    = rcs_pkg::tod_sec(item_ff.hour, item_ff.minute, item_ff.second);
         el_on_in  = item_ff.now_ms - last_on_ff;
         el_chg_in = item_ff.now_ms - last_chg_ff;
         since_in  = item_ff.epoch_s - cfg.start_epoch;
         cnt_in    = '0;
         any_in    = 1'b0;
      end

      if (state_ff == rcs_pkg::ST_MUL) begin
         on_ms_in  = rcs_pkg::MS_W'(dr_ff) * rcs_pkg::MS_PER_PCT_S;
         off_ms_in = rcs_pkg::MS_W'(r100_ff - dr_ff) * rcs_pkg::MS_PER_PCT_S;
      end

      if (state_ff == rcs_pkg::ST_SCAN) begin
         cnt_in = cnt_ff + rcs_pkg::SLOT_AW'(1);
      end

      if (rd_pend_ff && hit) begin
         any_in = 1'b1;
      end

      if (state_ff == rcs_pkg::ST_DECIDE) begin
         relay_in = relay_new;
         if (drive) begin
            last_chg_in = item_ff.now_ms;
            if (drive_on) begin
               last_on_in = item_ff.now_ms;
            end
         end
      end

      rsp_valid_in = (state_ff == rcs_pkg::ST_DECIDE);
      rsp_relay_in = relay_new;
      rsp_pin_in   = relay_new ? cfg.active_level : ~cfg.active_level;
      rsp_sw_in    = drive;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcs_pkg::ST_IDLE;
         relay_ff     <= 1'b0;
         last_on_ff   <= '0;
         last_chg_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         relay_ff     <= relay_in;
         last_on_ff   <= last_on_in;
         last_chg_ff  <= last_chg_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      cnt_ff       <= cnt_in;
      any_ff       <= any_in;
      duty_ff      <= duty_in;
      dr_ff        <= dr_in;
      r100_ff      <= r100_in;
      ao_ms_ff     <= ao_ms_in;
      on_ms_ff     <= on_ms_in;
      off_ms_ff    <= off_ms_in;
      cur_ff       <= cur_in;
      el_on_ff     <= el_on_in;
      el_chg_ff    <= el_chg_in;
      since_ff     <= since_in;
      rsp_relay_ff <= rsp_relay_in;
      rsp_pin_ff   <= rsp_pin_in;
      rsp_sw_ff    <= rsp_sw_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_relay_on  = rsp_relay_ff;
   assign rsp_pin_level = rsp_pin_ff;
   assign rsp_switched  = rsp_sw_ff;

   `RCS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff == rcs_pkg::ST_PREP, "accepted word did not start")
   `RCS_ASSERT_NEXT(a_decide_strobes, state_ff == rcs_pkg::ST_DECIDE, rsp_valid_ff && state_ff == rcs_pkg::ST_IDLE, "decision gave no result")
   `RCS_ASSERT_IMPLY(a_write_only_at_decide, mem_req.wr_en, state_ff == rcs_pkg::ST_DECIDE && !mem_req.rd_en, "table write outside decision")
   `RCS_ASSERT_IMPLY(a_result_matches_state, rsp_valid_ff, rsp_relay_ff == relay_ff, "result disagrees with relay state")

endmodule

// File: sv/relay_channel_scheduler_top.sv
// Relay channel scheduler, top level: one relay channel with its schedule and timer table.
// Depends on rcs_pkg, rcs_csr, rcs_slot_mem and rcs_ctrl.
//
// An item is taken when start is high and busy is low, and exactly one result word follows,
// shown on the rsp_ ports for a single cycle under rsp_valid; the receiver cannot stall it.
// Manual sets, slot writes, unknown requests, panic ticks and ticks outside daily-timer mode
// go through the PREP, MUL and DECIDE states before the result strobe. A tick without panic
// in daily-timer mode walks the timer table through its single read port, one entry a cycle,
// with registered read data, in SCAN and DRAIN between MUL and DECIDE. busy drops in the
// cycle the result is shown, so the next item can be taken then. The timer table needs no
// clearing pass: per-entry valid bits make it read as zero after reset. Configuration writes
// are always ready and take effect on the next cycle; write them only while the block is idle.
module relay_channel_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_epoch_s,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   input  logic        req_panic,
   input  logic        req_set_on,
   input  logic [2:0]  req_slot,
   input  logic [16:0] req_slot_duration,
   output logic        rsp_valid,
   output logic        rsp_relay_on,
   output logic        rsp_pin_level,
   output logic        rsp_switched,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   rcs_pkg::cfg_type     cfg;
   rcs_pkg::item_type    item;
   rcs_pkg::mem_req_type mem_req;
   rcs_pkg::slot_type    rd_data;

   always_comb begin
      item.op            = req_op;
      item.now_ms        = req_now_ms;
      item.epoch_s       = req_epoch_s;
      item.hour          = req_hour;
      item.minute        = req_minute;
      item.second        = req_second;
      item.panic         = req_panic;
      item.set_on        = req_set_on;
      item.slot          = req_slot;
      item.slot_duration = req_slot_duration;
   end

   rcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rcs_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   rcs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .item          (item),
      .cfg           (cfg),
      .mem_req       (mem_req),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_relay_on  (rsp_relay_on),
      .rsp_pin_level (rsp_pin_level),
      .rsp_switched  (rsp_switched)
   );

endmodule

// File: test/tb_relay_channel_scheduler_top.sv
// Self-checking testbench for relay_channel_scheduler_top: directed and random requests
// over every mode, with an in-bench prediction of the relay state. Depends on rcs_pkg and relay_channel_scheduler_top.
module tb_relay_channel_scheduler_top;
   import rcs_pkg::*;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 92;
   localparam int DRAIN_CYCLES = 4 * (5 + TIMER_SLOTS);
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic relay_on;
      logic pin_level;
      logic switched;
   } relay_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic [31:0] req_now_ms = '0;
   logic [31:0] req_epoch_s = '0;
   logic [4:0]  req_hour = '0;
   logic [5:0]  req_minute = '0;
   logic [5:0]  req_second = '0;
   logic        req_panic = 1'b0;
   logic        req_set_on = 1'b0;
   logic [2:0]  req_slot = '0;
   logic [16:0] req_slot_duration = '0;
   logic        rsp_valid;
   logic        rsp_relay_on;
   logic        rsp_pin_level;
   logic        rsp_switched;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   relay_channel_scheduler_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_now_ms(req_now_ms), .req_epoch_s(req_epoch_s),
      .req_hour(req_hour), .req_minute(req_minute), .req_second(req_second),
      .req_panic(req_panic), .req_set_on(req_set_on), .req_slot(req_slot),
      .req_slot_duration(req_slot_duration),
      .rsp_valid(rsp_valid), .rsp_relay_on(rsp_relay_on), .rsp_pin_level(rsp_pin_level),
      .rsp_switched(rsp_switched),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   item_type       requests_pending[$];
   relay_word_type relay_words_due[$];
   int             sender_idle_pct = 0;

   // Shadow copy of the channel: registers, relay state and the timer table.
   cfg_type     cfg_model;
   slot_type    slots_model [TIMER_SLOTS];
   logic        relay_model;
   logic [31:0] on_stamp;
   logic [31:0] change_stamp;
   logic        relay_written;

   // Running time bases for well-formed random ticks.
   logic [31:0] gen_ms = '0;
   logic [31:0] gen_epoch = '0;
   int unsigned gen_tod = 0;
   int unsigned ms_step = 1000;

   int mismatches = 0;
   int tick_count = 0, set_count = 0, slot_count = 0, unknown_count = 0;
   int write_count = 0, settings_count = 0;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void switch_relay(input logic on, input logic [31:0] now);
      relay_model = on;
      change_stamp = now;
      if (on)
         on_stamp = now;
      relay_written = 1'b1;
   endfunction

   function automatic relay_word_type next_relay_word(input item_type it);
      relay_word_type word;
      logic [31:0] since_on, since_change, span, duty, now_tod, open_at, epoch_gap;
      logic any_open;
      int k;
      relay_written = 1'b0;
      since_on = it.now_ms - on_stamp;
      since_change = it.now_ms - change_stamp;
      case (it.op)
         OP_TICK: begin
            if (it.panic) begin
               switch_relay(1'b0, it.now_ms);
            end else begin
               case (cfg_model.mode)
                  MODE_MANUAL: begin
                     if (cfg_model.auto_off_s != 0 && relay_model &&
                         since_on >= 32'(cfg_model.auto_off_s) * 32'd1000)
                        switch_relay(1'b0, it.now_ms);
                  end
                  MODE_DUTY: begin
                     span = (cfg_model.duty_range_s < 16'd2) ? 32'd2 :
                            32'(cfg_model.duty_range_s);
                     duty = (cfg_model.duty_percent > 7'd100) ? 32'd100 :
                            32'(cfg_model.duty_percent);
                     if (duty != 0) begin
                        if (relay_model) begin
                           if (duty != 100 && since_change >= duty * span * 32'd10)
                              switch_relay(1'b0, it.now_ms);
                        end else if (since_change >= (32'd100 - duty) * span * 32'd10) begin
                           switch_relay(1'b1, it.now_ms);
                        end
                     end
                  end
                  MODE_DAILY: begin
                     now_tod = 32'(it.hour) * 3600 + 32'(it.minute) * 60 + 32'(it.second);
                     any_open = 1'b0;
                     for (k = 0; k < TIMER_SLOTS; k++) begin
                        open_at = 32'(slots_model[k].hour) * 3600 +
                                  32'(slots_model[k].minute) * 60 + 32'(slots_model[k].second);
                        if (open_at <= now_tod && open_at + 32'(slots_model[k].duration) >= now_tod)
                           any_open = 1'b1;
                     end
                     if (!relay_model && any_open)
                        switch_relay(1'b1, it.now_ms);
                     else if (relay_model && !any_open)
                        switch_relay(1'b0, it.now_ms);
                  end
                  MODE_EPOCH: begin
                     if (cfg_model.run_duration_s != 0) begin
                        epoch_gap = it.epoch_s - cfg_model.start_epoch;
                        if (cfg_model.start_epoch <= it.epoch_s &&
                            cfg_model.run_duration_s >= epoch_gap && !relay_model)
                           switch_relay(1'b1, it.now_ms);
                        else if (relay_model && cfg_model.run_duration_s <= epoch_gap)
                           switch_relay(1'b0, it.now_ms);
                     end
                  end
               endcase
            end
         end
         OP_SET: switch_relay(it.set_on, it.now_ms);
         OP_SLOT: begin
            if (32'(it.slot) < TIMER_SLOTS)
               slots_model[it.slot] = '{it.hour, it.minute, it.second, it.slot_duration};
         end
         default: ;
      endcase
      word.relay_on = relay_model;
      word.pin_level = relay_model ? cfg_model.active_level : ~cfg_model.active_level;
      word.switched = relay_written;
      return word;
   endfunction

   function automatic item_type make_request(input logic [1:0] op,
                                             input logic [31:0] now, epoch,
                                             input logic [4:0] h, input logic [5:0] m, s,
                                             input logic panic_bit, on_bit,
                                             input logic [2:0] slot_idx,
                                             input logic [16:0] dur);
      item_type it;
      it = '{op, now, epoch, h, m, s, panic_bit, on_bit, slot_idx, dur};
      return it;
   endfunction

   // Mostly ticks on advancing time bases; fields a request does not use stay random.
   function automatic item_type random_request(input logic [1:0] phase_mode);
      item_type it;
      int unsigned roll, set_pct, slot_pct, open_tod;
      it.op = OP_TICK;
      it.now_ms = $urandom;
      it.epoch_s = $urandom;
      it.hour = 5'($urandom);
      it.minute = 6'($urandom);
      it.second = 6'($urandom);
      it.panic = 1'($urandom);
      it.set_on = 1'($urandom);
      it.slot = 3'($urandom);
      it.slot_duration = 17'($urandom);
      gen_ms += 32'($urandom_range(ms_step));
      gen_epoch += 32'($urandom_range(2));
      gen_tod = (gen_tod + $urandom_range(30)) % 86400;
      set_pct = (phase_mode == MODE_MANUAL) ? 15 : 5;
      slot_pct = (phase_mode == MODE_DAILY) ? 12 : 5;
      roll = $urandom_range(99);
      if (roll == 0) begin
         it.op = OP_UNKNOWN;
      end else if (roll < 4) begin
         // Noise: time and window fields exactly as drawn, out-of-range values included.
         it.op = (roll == 1) ? OP_TICK : OP_SLOT;
      end else if (roll < 4 + set_pct) begin
         it.op = OP_SET;
         it.now_ms = gen_ms;
      end else if (roll < 4 + set_pct + slot_pct) begin
         it.op = OP_SLOT;
         open_tod = (gen_tod + 86400 + $urandom_range(60) - $urandom_range(300)) % 86400;
         it.hour = 5'(open_tod / 3600);
         it.minute = 6'((open_tod / 60) % 60);
         it.second = 6'(open_tod % 60);
         if ($urandom_range(3) != 0)
            it.slot_duration = 17'($urandom_range(400));
      end else begin
         it.now_ms = gen_ms;
         it.epoch_s = gen_epoch;
         it.hour = 5'(gen_tod / 3600);
         it.minute = 6'((gen_tod / 60) % 60);
         it.second = 6'(gen_tod % 60);
         it.panic = ($urandom_range(99) < 3);
      end
      return it;
   endfunction

   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_requests();
      do @(negedge clock);
      while (requests_pending.size() != 0 || start || relay_words_due.size() != 0);
   endtask

   // Request driver: a new word goes out when none is shown or the shown one is taken.
   always @(posedge clock) begin
      item_type head;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (requests_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            head = requests_pending.pop_front();
            start <= 1'b1;
            req_op <= head.op;
            req_now_ms <= head.now_ms;
            req_epoch_s <= head.epoch_s;
            req_hour <= head.hour;
            req_minute <= head.minute;
            req_second <= head.second;
            req_panic <= head.panic;
            req_set_on <= head.set_on;
            req_slot <= head.slot;
            req_slot_duration <= head.slot_duration;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: results are checked before a request taken on the same edge is predicted.
   always @(posedge clock) begin
      relay_word_type want;
      item_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:         cfg_model.mode = csr_data[1:0];
               CSR_DUTY_PERCENT: cfg_model.duty_percent = csr_data[6:0];
               CSR_DUTY_RANGE:   cfg_model.duty_range_s = csr_data[15:0];
               CSR_AUTO_OFF:     cfg_model.auto_off_s = csr_data[15:0];
               CSR_START_EPOCH:  cfg_model.start_epoch = csr_data;
               CSR_RUN_DURATION: cfg_model.run_duration_s = csr_data;
               CSR_ACTIVE_LEVEL: cfg_model.active_level = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (relay_words_due.size() == 0) begin
               if (mismatches < 10)
                  $display("%0d: unexpected result word relay_on %b pin_level %b switched %b",
                           cycle_count, rsp_relay_on, rsp_pin_level, rsp_switched);
               mismatches++;
            end else begin
               want = relay_words_due.pop_front();
               if (rsp_switched === 1'b1)
                  write_count++;
               if (rsp_relay_on !== want.relay_on || rsp_pin_level !== want.pin_level ||
                   rsp_switched !== want.switched) begin
                  if (mismatches < 10)
                     $display("%0d: mismatch relay_on/pin_level/switched: expected %b %b %b, got %b %b %b",
                              cycle_count, want.relay_on, want.pin_level, want.switched,
                              rsp_relay_on, rsp_pin_level, rsp_switched);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            seen = '{req_op, req_now_ms, req_epoch_s, req_hour, req_minute, req_second,
                     req_panic, req_set_on, req_slot, req_slot_duration};
            relay_words_due.push_back(next_relay_word(seen));
            case (req_op)
               OP_TICK: tick_count++;
               OP_SET:  set_count++;
               OP_SLOT: slot_count++;
               default: unknown_count++;
            endcase
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at %0d cycles with %0d words pending and %0d results due.",
               cycle_count, requests_pending.size(), relay_words_due.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int phase;
      int unsigned extreme;
      cfg_type plan;

      cfg_model = '0;
      cfg_model.active_level = 1'b1;
      relay_model = 1'b0;
      on_stamp = '0;
      change_stamp = '0;
      foreach (slots_model[k])
         slots_model[k] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Manual mode: auto-off at its longest, panic, unknown op, a slot at its extremes.
      write_csr(CSR_AUTO_OFF, 32'd65535);
      @(negedge clock);
      requests_pending.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_SET, 100, 0, 0, 0, 0, 0, 1, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, '1, 0, 0, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_SET, 200, 0, 0, 0, 0, 0, 1, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 300, 0, 0, 0, 0, 1, 0, 0, 0));
      requests_pending.push_back(make_request(OP_UNKNOWN, '1, '1, '1, '1, '1, 1, 1, '1, '1));
      requests_pending.push_back(make_request(OP_SLOT, 400, 0, 31, 63, 63, 0, 0, 7, '1));
      drain_requests();
      settings_count++;

      // Auto-off across the wrap of the millisecond counter, inverted pin level.
      write_csr(CSR_AUTO_OFF, 32'd1);
      write_csr(CSR_ACTIVE_LEVEL, 32'd0);
      @(negedge clock);
      requests_pending.push_back(make_request(OP_SET, 32'hFFFF_FC00, 0, 0, 0, 0, 0, 1, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h0000_00E8, 0, 0, 0, 0, 0, 0, 0, 0));
      drain_requests();
      settings_count++;

      // Duty above full saturates and never switches off; range below minimum counts as 2.
      write_csr(CSR_MODE, 32'(MODE_DUTY));
      write_csr(CSR_DUTY_PERCENT, 32'd127);
      write_csr(CSR_DUTY_RANGE, 32'd0);
      @(negedge clock);
      requests_pending.push_back(make_request(OP_TICK, 32'h1000, 0, 0, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h2000, 0, 0, 0, 0, 0, 0, 0, 0));
      drain_requests();
      settings_count++;

      write_csr(CSR_DUTY_PERCENT, 32'd50);
      write_csr(CSR_DUTY_RANGE, 32'd1);
      @(negedge clock);
      requests_pending.push_back(make_request(OP_TICK, 32'h1000 + 999, 0, 0, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h1000 + 1000, 0, 0, 0, 0, 0, 0, 0, 0));
      drain_requests();
      settings_count++;

      // Daily windows: cleared slots match midnight, out-of-range time, exact boundaries.
      write_csr(CSR_MODE, 32'(MODE_DAILY));
      @(negedge clock);
      requests_pending.push_back(make_request(OP_TICK, 32'h3000, 0, 0, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h3001, 0, 31, 63, 63, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h3002, 0, 12, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_SLOT, 32'h3003, 0, 12, 0, 0, 0, 0, 3, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h3004, 0, 12, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h3005, 0, 12, 0, 1, 0, 0, 0, 0));
      drain_requests();
      settings_count++;

      // Epoch window at the top of the epoch range, then closing exactly at its length.
      write_csr(CSR_MODE, 32'(MODE_EPOCH));
      write_csr(CSR_START_EPOCH, 32'hFFFF_FFFF);
      write_csr(CSR_RUN_DURATION, 32'hFFFF_FFFF);
      write_csr(CSR_ACTIVE_LEVEL, 32'd1);
      @(negedge clock);
      requests_pending.push_back(make_request(OP_TICK, 32'h4000, '1, 0, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h4001, 5, 0, 0, 0, 0, 0, 0, 0));
      drain_requests();
      settings_count++;

      write_csr(CSR_START_EPOCH, 32'd100);
      write_csr(CSR_RUN_DURATION, 32'd10);
      @(negedge clock);
      requests_pending.push_back(make_request(OP_TICK, 32'h4002, 110, 0, 0, 0, 0, 0, 0, 0));
      requests_pending.push_back(make_request(OP_TICK, 32'h4003, 110, 0, 0, 0, 0, 0, 0, 0));
      drain_requests();
      settings_count++;

      write_csr(CSR_RUN_DURATION, 32'd0);
      @(negedge clock);
      requests_pending.push_back(make_request(OP_TICK, 32'h4004, 50, 0, 0, 0, 0, 0, 0, 0));
      drain_requests();
      settings_count++;

      // Random phases: the first two take every register but the mode at its low and high extreme.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         plan.mode = 2'(phase % 4);
         extreme = (phase < 2) ? phase + 1 : 0;
         if (extreme == 1) begin
            plan.duty_percent = 7'd0;
            plan.duty_range_s = 16'd0;
            plan.auto_off_s = 16'd0;
            plan.start_epoch = 32'd0;
            plan.run_duration_s = 32'd0;
            plan.active_level = 1'b0;
         end else if (extreme == 2) begin
            plan.duty_percent = 7'd127;
            plan.duty_range_s = 16'hFFFF;
            plan.auto_off_s = 16'hFFFF;
            plan.start_epoch = 32'hFFFF_FFFF;
            plan.run_duration_s = 32'hFFFF_FFFF;
            plan.active_level = 1'b1;
         end else begin
            case ($urandom_range(5))
               0: plan.duty_percent = 7'd0;
               1: plan.duty_percent = 7'd100;
               2: plan.duty_percent = 7'($urandom_range(127, 101));
               default: plan.duty_percent = 7'($urandom_range(99, 1));
            endcase
            plan.duty_range_s = ($urandom_range(4) == 0) ? 16'($urandom_range(1)) :
                                16'($urandom_range(6, 2));
            plan.auto_off_s = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(5, 1));
            plan.start_epoch = $urandom;
            plan.run_duration_s = ($urandom_range(4) == 0) ? 32'd0 :
                                  32'($urandom_range(30, 1));
            plan.active_level = 1'($urandom);
         end
         write_csr(CSR_MODE, 32'(plan.mode));
         write_csr(CSR_DUTY_PERCENT, 32'(plan.duty_percent));
         write_csr(CSR_DUTY_RANGE, 32'(plan.duty_range_s));
         write_csr(CSR_AUTO_OFF, 32'(plan.auto_off_s));
         write_csr(CSR_START_EPOCH, plan.start_epoch);
         write_csr(CSR_RUN_DURATION, plan.run_duration_s);
         write_csr(CSR_ACTIVE_LEVEL, 32'(plan.active_level));
         @(negedge clock);
         sender_idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 84 : 31;
         ms_step = $urandom_range(3000, 200);
         if ($urandom_range(3) == 0)
            gen_ms = 32'hFFFF_FFFF - 32'($urandom_range(20000));
         gen_epoch = plan.start_epoch - 32'($urandom_range(8));
         repeat (ITEMS_PER_PHASE)
            requests_pending.push_back(random_request(plan.mode));
         drain_requests();
         settings_count++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d ticks, %0d manual sets, %0d slot writes and %0d unknown requests.",
               tick_count, set_count, slot_count, unknown_count);
      $display("All four modes ran under %0d register settings; %0d results were relay writes.",
               settings_count, write_count);
      if (mismatches == 0 && relay_words_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/rcs_pkg.sv
sv/rcs_csr.sv
sv/rcs_slot_mem.sv
sv/rcs_ctrl.sv
sv/relay_channel_scheduler_top.sv
test/tb_relay_channel_scheduler_top.sv
